// ===== rtl/sorted_key_table_defines.svh =====
// assertion helpers for the sorted key table
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF

`define SKT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sorted key table check failed");

`define SKT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key table sequence check failed");

`else

`define SKT_ASSERT(lbl, prop)

`define SKT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/skt_pkg.sv =====
`timescale 1ns / 1ps

package skt_pkg;

    localparam int DEPTH_DEFAULT     = 256;
    localparam int KEY_WIDTH_DEFAULT = 32;

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 9;
    localparam int COUNT_W  = 9;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_SEARCH = 3'd1,
        OP_DELETE = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        status_t            status;
        logic               found;
        logic [POS_W-1:0]   position;
        logic [KEY_W-1:0]   key_out;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

endpackage

// ===== rtl/skt_ram.sv =====
`timescale 1ns / 1ps

module skt_ram #(
    parameter int DEPTH     = skt_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEFAULT,
    localparam int AW       = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [KEY_WIDTH-1:0] wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [KEY_WIDTH-1:0] rd_data
);

    logic [KEY_WIDTH-1:0] mem [DEPTH];
    logic [KEY_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/skt_seq.sv =====
`timescale 1ns / 1ps
`include "sorted_key_table_defines.svh"

module skt_seq #(
    parameter int DEPTH     = skt_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         ready,
    input  logic [skt_pkg::OP_W-1:0]     op,
    input  logic [skt_pkg::KEY_W-1:0]    key,
    input  logic [skt_pkg::IDX_W-1:0]    index,
    input  logic                         allow_dup,
    output logic                         res_valid,
    input  logic                         res_ready,
    output skt_pkg::result_t             res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > skt_pkg::IDX_W) ? CW : skt_pkg::IDX_W;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_SRCH     = 12'b0000_0000_0010,
        S_PROBE    = 12'b0000_0000_0100,
        S_HITCHK   = 12'b0000_0000_1000,
        S_DECIDE   = 12'b0000_0001_0000,
        S_UP_START = 12'b0000_0010_0000,
        S_UP_MOVE  = 12'b0000_0100_0000,
        S_PUT_KEY  = 12'b0000_1000_0000,
        S_RD_WAIT  = 12'b0001_0000_0000,
        S_DN_START = 12'b0010_0000_0000,
        S_DN_MOVE  = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } state_t;

    state_t                         state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    skt_pkg::op_t                   op_reg, op_next;
    logic [KEY_WIDTH-1:0]           key_reg, key_next;
    logic [CW-1:0]                  lo_reg, lo_next;
    logic [CW-1:0]                  hi_reg, hi_next;
    logic [CW-1:0]                  mid_reg, mid_next;
    logic [AW-1:0]                  ptr_reg, ptr_next;
    logic                           hit_reg, hit_next;
    skt_pkg::status_t               status_reg, status_next;
    logic                           found_reg, found_next;
    logic [skt_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [skt_pkg::KEY_W-1:0]      kout_reg, kout_next;

    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [KEY_WIDTH-1:0]           mem_wdata;
    logic                           mem_re;
    logic [AW-1:0]                  mem_raddr;
    logic [KEY_WIDTH-1:0]           mem_rdata;

    logic                           key_lt;
    logic                           key_eq;
    logic [CW-1:0]                  mid_calc;

    skt_ram #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr   (mem_raddr),
        .rd_data (mem_rdata)
    );

    // the one shared compare unit
    assign key_lt   = mem_rdata < key_reg;
    assign key_eq   = mem_rdata == key_reg;
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        ptr_next    = ptr_reg;
        hit_next    = hit_reg;
        status_next = status_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        kout_next   = kout_reg;
        mem_we      = 1'b0;
        mem_waddr   = ptr_reg;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = skt_pkg::op_t'(op);
                    key_next    = KEY_WIDTH'(key);
                    status_next = skt_pkg::ST_OK;
                    found_next  = 1'b0;
                    pos_next    = '0;
                    kout_next   = '0;
                    unique case (op) inside
                        skt_pkg::OP_INSERT, skt_pkg::OP_SEARCH:
                        begin
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = S_SRCH;
                        end
                        skt_pkg::OP_DELETE, skt_pkg::OP_READ:
                        begin
                            pos_next = skt_pkg::POS_W'(index);
                            if (IW'(index) >= IW'(count_reg))
                            begin
                                status_next = skt_pkg::ST_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(index);
                                ptr_next   = AW'(index);
                                state_next = S_RD_WAIT;
                            end
                        end
                        skt_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(mid_calc);
                    state_next = S_PROBE;
                end
                else
                begin
                    pos_next = skt_pkg::POS_W'(lo_reg);
                    if (lo_reg < count_reg)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = AW'(lo_reg);
                        state_next = S_HITCHK;
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        state_next = S_DECIDE;
                    end
                end
            end
            S_PROBE:
            begin
                if (key_lt)
                begin
                    lo_next = mid_reg + CW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_HITCHK:
            begin
                hit_next   = key_eq;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                found_next = hit_reg;
                if (op_reg == skt_pkg::OP_SEARCH)
                begin
                    status_next = hit_reg ? skt_pkg::ST_OK : skt_pkg::ST_MISS;
                    kout_next   = hit_reg ? skt_pkg::KEY_W'(key_reg) : '0;
                    state_next  = S_DONE;
                end
                else if (hit_reg && !allow_dup)
                begin
                    status_next = skt_pkg::ST_MISS;
                    state_next  = S_DONE;
                end
                else if (count_reg >= CW'(DEPTH))
                begin
                    status_next = skt_pkg::ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    ptr_next   = AW'(count_reg);
                    state_next = S_UP_START;
                end
            end
            S_UP_START:
            begin
                if (CW'(ptr_reg) == lo_reg)
                begin
                    state_next = S_PUT_KEY;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_reg - AW'(1);
                    state_next = S_UP_MOVE;
                end
            end
            S_UP_MOVE:
            begin
                // write the word fetched last cycle one place up, fetch the next
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                ptr_next  = ptr_reg - AW'(1);
                if (CW'(ptr_reg) - CW'(1) == lo_reg)
                begin
                    state_next = S_PUT_KEY;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg - AW'(2);
                end
            end
            S_PUT_KEY:
            begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(lo_reg);
                mem_wdata  = key_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_RD_WAIT:
            begin
                kout_next  = skt_pkg::KEY_W'(mem_rdata);
                state_next = (op_reg == skt_pkg::OP_DELETE) ? S_DN_START : S_DONE;
            end
            S_DN_START:
            begin
                if (CW'(ptr_reg) + CW'(1) >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_reg + AW'(1);
                    state_next = S_DN_MOVE;
                end
            end
            S_DN_MOVE:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                ptr_next  = ptr_reg + AW'(1);
                if (CW'(ptr_reg) + CW'(2) < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + AW'(2);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        ptr_reg    <= ptr_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        kout_reg   <= kout_next;
    end

    assign ready     = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.status      = status_reg;
        res.found       = found_reg;
        res.position    = pos_reg;
        res.key_out     = kout_reg;
        res.entry_count = skt_pkg::COUNT_W'(count_reg);
    end

    `SKT_ASSERT(a_count_bound, count_reg <= CW'(DEPTH))
    `SKT_ASSERT(a_search_window, (state_reg != S_SRCH) || ((lo_reg <= hi_reg) && (hi_reg <= count_reg)))
    `SKT_ASSERT(a_write_in_range, !mem_we || (CW'(mem_waddr) <= count_reg))
    `SKT_ASSERT_NEXT(a_insert_grows, state_reg == S_PUT_KEY, count_reg == $past(count_reg) + CW'(1))
    `SKT_ASSERT(a_no_write_when_idle, !(ready && mem_we))

endmodule

// ===== rtl/sorted_key_table.sv =====
`timescale 1ns / 1ps

// sorted key table: an ascending table of unsigned keys with insert, search,
// delete at index, read at index and clear. one transaction in gives one
// transaction out. insert and search run a binary search (lower bound) one
// probe at a time through a key memory with one registered read port and one
// write port. each probe reads the middle entry and then compares it with the
// key, and when the search ends below the count one more read checks that
// position for an equal key. insert then moves each later entry up one place
// at one memory word per cycle, and delete moves each later entry down the
// same way. the one read port, the one write port and the shared key
// comparator set the pace of these steps.
// a new transaction is taken only while the sequencer is idle, but a finished
// result sits in its own output register, so the next transaction can start
// while the previous result is still stalled. keys wider than KEY_WIDTH are
// cut to their low bits. allow_duplicates (cfg_wr_en / cfg_wr_data, reset 0)
// lets equal keys in, placed in front of the first equal entry; write it only
// while no transaction is in flight. entries at or above the count are never
// read, so the key memory needs no clearing after reset.

module sorted_key_table #(
    parameter int DEPTH     = skt_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,

    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [skt_pkg::OP_W-1:0]        op,
    input  logic [skt_pkg::KEY_W-1:0]       key,
    input  logic [skt_pkg::IDX_W-1:0]       index,

    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [skt_pkg::STATUS_W-1:0]    status,
    output logic                            found,
    output logic [skt_pkg::POS_W-1:0]       position,
    output logic [skt_pkg::KEY_W-1:0]       key_out,
    output logic [skt_pkg::COUNT_W-1:0]     entry_count
);

    // duplicate policy register
    logic                 allow_dup_reg, allow_dup_next;

    // sequencer handshake
    logic                 seq_ready;
    logic                 seq_start;
    logic                 seq_res_valid;
    logic                 seq_res_ready;
    skt_pkg::result_t     seq_res;

    // output register stage
    logic                 out_valid_reg, out_valid_next;
    skt_pkg::result_t     out_res_reg, out_res_next;
    logic                 out_load;

    assign in_stall  = !seq_ready;
    assign seq_start = in_valid && seq_ready;

    // the output slot is free when empty or being drained this cycle
    assign seq_res_ready = !out_valid_reg || !out_stall;
    assign out_load      = seq_res_valid && seq_res_ready;

    skt_seq #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (seq_start),
        .ready     (seq_ready),
        .op        (op),
        .key       (key),
        .index     (index),
        .allow_dup (allow_dup_reg),
        .res_valid (seq_res_valid),
        .res_ready (seq_res_ready),
        .res       (seq_res)
    );

    always_comb
    begin
        allow_dup_next = cfg_wr_en ? cfg_wr_data : allow_dup_reg;
        out_valid_next = out_load || (out_valid_reg && out_stall);
        out_res_next   = out_load ? seq_res : out_res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_dup_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            allow_dup_reg <= allow_dup_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload holds while stalled
    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign found       = out_res_reg.found;
    assign position    = out_res_reg.position;
    assign key_out     = out_res_reg.key_out;
    assign entry_count = out_res_reg.entry_count;

endmodule
